// ===== sv/sorted_angle_gap_engine_assert.svh =====
// Assertion macros shared by the sorted angle gap engine RTL.
// No dependencies; include by bare file name.
`ifndef SORTED_ANGLE_GAP_ENGINE_ASSERT_SVH
`define SORTED_ANGLE_GAP_ENGINE_ASSERT_SVH

// same-cycle implication
`define SAGE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted angle gap engine: assertion failed");

// next-cycle implication
`define SAGE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted angle gap engine: assertion failed");

`endif

// ===== sv/sage_pkg.sv =====
// Package for the sorted angle gap engine: sizes, constants and shared types.
// No dependencies; used by the interfaces, the cell and the top level.
`timescale 1ns / 1ps

package sage_pkg;

   localparam int MAX_EDGES       = 16;
   localparam int ANGLE_FRAC_BITS = 7;
   localparam int ANGLE_W         = 16;
   localparam int OUT_POS_W       = 4;
   localparam int POS_W           = $clog2(MAX_EDGES);
   localparam int CNT_W           = $clog2(MAX_EDGES + 1);
   localparam int FULL_CIRCLE_INT = 360 << ANGLE_FRAC_BITS;
   localparam logic [ANGLE_W-1:0] FULL_CIRCLE = ANGLE_W'(FULL_CIRCLE_INT);

   typedef struct packed {
      logic               valid;
      logic [ANGLE_W-1:0] angle;
      logic [POS_W-1:0]   pos;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } chain_ctrl_type;

   typedef struct packed {
      logic [OUT_POS_W-1:0] load_position;
      logic [ANGLE_W-1:0]   sorted_angle;
      logic [ANGLE_W-1:0]   gap;
      logic                 overflow;
      logic                 last_result;
   } rsp_item_type;

   typedef enum logic {
      ST_LOAD,
      ST_EMIT
   } state_type;

endpackage

// ===== sv/sage_req_if.sv =====
// Input channel of the sorted angle gap engine: valid, ready and one angle item.
// Depends on sage_pkg.
`timescale 1ns / 1ps

interface sage_req_if;
   logic                         valid;
   logic                         ready;
   logic [sage_pkg::ANGLE_W-1:0] angle;
   logic                         is_last;

   modport source (output valid, output angle, output is_last, input ready);
   modport sink (input valid, input angle, input is_last, output ready);
endinterface

// ===== sv/sage_rsp_if.sv =====
// Result channel of the sorted angle gap engine: valid, ready and one result item.
// Depends on sage_pkg.
`timescale 1ns / 1ps

interface sage_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sage_pkg::OUT_POS_W-1:0] load_position;
   logic [sage_pkg::ANGLE_W-1:0]   sorted_angle;
   logic [sage_pkg::ANGLE_W-1:0]   gap;
   logic                           overflow;
   logic                           last_result;

   modport source (output valid, output load_position, output sorted_angle,
                   output gap, output overflow, output last_result, input ready);
   modport sink (input valid, input load_position, input sorted_angle,
                 input gap, input overflow, input last_result, output ready);
endinterface

// ===== sv/sorted_angle_gap_engine.sv =====
// Sorted angle gap engine: usage
// req_if carries one bearing angle per item (unsigned, 7 fraction bits,
// clamped to 360 degrees) and is_last, which closes the set. rsp_if returns
// one item per stored angle in ascending order (equal angles in load order)
// with load position, angle, gap to the previous angle, overflow and
// last_result. The first result gets 360 minus the largest plus the smallest.
// Loading: one item per cycle into a chain of MAX_EDGES cells; each cell
// compares against the new angle and the tail shifts right by one cell.
// Angles beyond MAX_EDGES are dropped and overflow is set for that set.
// Emitting: the closing item moves the engine to the emit state, which
// registers the first result once the output register is free, then one
// result per cycle while rsp_if.ready holds; the chain shifts left one cell
// per result. The last result may still sit in the output register while
// loading of the next set already starts. req_if.ready is low while results
// are being drawn from the chain; a stalled receiver holds the output
// register and the chain. Reset (synchronous) empties the chain and the
// output register.
// Depends on sage_pkg, sage_req_if, sage_rsp_if, sage_cell and the assertion
// macro header.
`timescale 1ns / 1ps
`include "sorted_angle_gap_engine_assert.svh"

module sorted_angle_gap_engine (
   input  logic  clock,
   input  logic  reset,
   sage_req_if.sink   req_if,
   sage_rsp_if.source rsp_if
);

   sage_pkg::state_type           state_ff, state_in;
   logic [sage_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [sage_pkg::CNT_W-1:0]    remaining_ff, remaining_in;
   logic                          overflow_ff, overflow_in;
   logic                          first_ff, first_in;
   logic [sage_pkg::ANGLE_W-1:0]  max_ff, max_in;
   logic [sage_pkg::ANGLE_W-1:0]  prev_ff, prev_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   sage_pkg::rsp_item_type        rsp_ff, rsp_in;

   logic                          in_take;
   logic                          space;
   logic                          out_free;
   logic                          emit_fire;
   logic [sage_pkg::ANGLE_W-1:0]  angle_clamped;
   logic [sage_pkg::ANGLE_W:0]    wrap_gap;
   sage_pkg::chain_ctrl_type      ctrl;
   sage_pkg::entry_type           new_entry;
   sage_pkg::entry_type           empty_entry;
   sage_pkg::entry_type           cells [sage_pkg::MAX_EDGES];
   logic                          gts [sage_pkg::MAX_EDGES];

   assign req_if.ready = (state_ff == sage_pkg::ST_LOAD);
   assign in_take      = req_if.valid && req_if.ready;
   assign space        = (count_ff < sage_pkg::CNT_W'(sage_pkg::MAX_EDGES));
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign emit_fire    = (state_ff == sage_pkg::ST_EMIT) && out_free;

   assign angle_clamped = (req_if.angle > sage_pkg::FULL_CIRCLE) ?
                          sage_pkg::FULL_CIRCLE : req_if.angle;

   assign new_entry.valid = 1'b1;
   assign new_entry.angle = angle_clamped;
   assign new_entry.pos   = sage_pkg::POS_W'(count_ff);

   assign empty_entry.valid = 1'b0;
   assign empty_entry.angle = '0;
   assign empty_entry.pos   = '0;

   assign ctrl.insert = in_take && space;
   assign ctrl.shift  = emit_fire;

   for (genvar i = 0; i < sage_pkg::MAX_EDGES; i++) begin : g_cell
      sage_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .left_entry  ((i == 0) ? empty_entry : cells[(i == 0) ? 0 : i - 1]),
         .left_gt     ((i == 0) ? 1'b0 : gts[(i == 0) ? 0 : i - 1]),
         .right_entry ((i == sage_pkg::MAX_EDGES - 1) ? empty_entry :
                       cells[(i == sage_pkg::MAX_EDGES - 1) ? i : i + 1]),
         .entry       (cells[i]),
         .gt          (gts[i])
      );
   end

   // circular gap; equals full circle for a lone angle since max equals min
   assign wrap_gap = {1'b0, sage_pkg::FULL_CIRCLE} - {1'b0, max_ff}
                     + {1'b0, cells[0].angle};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remaining_in = remaining_ff;
      overflow_in  = overflow_ff;
      first_in     = first_ff;
      max_in       = max_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         sage_pkg::ST_LOAD: begin
            if (in_take) begin
               if (space) begin
                  count_in = count_ff + 1'b1;
                  if ((count_ff == '0) || (angle_clamped > max_ff)) begin
                     max_in = angle_clamped;
                  end
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_if.is_last) begin
                  state_in     = sage_pkg::ST_EMIT;
                  remaining_in = space ? count_ff + 1'b1 : count_ff;
                  first_in     = 1'b1;
               end
            end
         end
         sage_pkg::ST_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in         = 1'b1;
               rsp_in.load_position = sage_pkg::OUT_POS_W'(cells[0].pos);
               rsp_in.sorted_angle  = cells[0].angle;
               rsp_in.gap           = first_ff ? wrap_gap[sage_pkg::ANGLE_W-1:0] :
                                      cells[0].angle - prev_ff;
               rsp_in.overflow      = overflow_ff;
               rsp_in.last_result   = (remaining_ff == sage_pkg::CNT_W'(1));
               prev_in              = cells[0].angle;
               first_in             = 1'b0;
               remaining_in         = remaining_ff - 1'b1;
               if (remaining_ff == sage_pkg::CNT_W'(1)) begin
                  state_in    = sage_pkg::ST_LOAD;
                  count_in    = '0;
                  overflow_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = sage_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sage_pkg::ST_LOAD;
         count_ff     <= '0;
         remaining_ff <= '0;
         overflow_ff  <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remaining_ff <= remaining_in;
         overflow_ff  <= overflow_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      max_ff  <= max_in;
      prev_ff <= prev_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.load_position = rsp_ff.load_position;
   assign rsp_if.sorted_angle  = rsp_ff.sorted_angle;
   assign rsp_if.gap           = rsp_ff.gap;
   assign rsp_if.overflow      = rsp_ff.overflow;
   assign rsp_if.last_result   = rsp_ff.last_result;

   `SAGE_ASSERT_NOW(a_emit_has_work, clock, reset, state_ff == sage_pkg::ST_EMIT, remaining_ff != '0 && cells[0].valid)
   `SAGE_ASSERT_NOW(a_count_in_range, clock, reset, 1'b1, count_ff <= sage_pkg::CNT_W'(sage_pkg::MAX_EDGES))
   `SAGE_ASSERT_NEXT(a_run_end_clears, clock, reset, emit_fire && remaining_ff == sage_pkg::CNT_W'(1), state_ff == sage_pkg::ST_LOAD && count_ff == '0 && !overflow_ff && rsp_if.last_result)
   `SAGE_ASSERT_NEXT(a_close_starts_emit, clock, reset, in_take && req_if.is_last, state_ff == sage_pkg::ST_EMIT && first_ff)

endmodule

// ===== sv/sage_cell.sv =====
// One cell of the sorting chain: holds one sorted entry, inserts or shifts.
// Depends on sage_pkg.
`timescale 1ns / 1ps

module sage_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  sage_pkg::chain_ctrl_type ctrl,
   input  sage_pkg::entry_type      new_entry,
   input  sage_pkg::entry_type      left_entry,
   input  logic                     left_gt,
   input  sage_pkg::entry_type      right_entry,
   output sage_pkg::entry_type      entry,
   output logic                     gt
);

   sage_pkg::entry_type entry_ff;
   sage_pkg::entry_type entry_in;

   // empty cells rank above every angle
   assign gt    = !entry_ff.valid || (entry_ff.angle > new_entry.angle);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift) begin
         entry_in = right_entry;
      end else if (ctrl.insert && gt) begin
         entry_in = left_gt ? left_entry : new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule
